// ===== rtl/kmsh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmsh_pkg
// Shared types and constants of the key matrix scanner and report builder.
// ----------------------------------------------------------------------------
package kmsh_pkg;

  localparam int unsigned COLS         = 8;
  localparam int unsigned NUM_SLOTS    = 6;
  localparam int unsigned REPORT_BYTES = 8;

  // key code classes
  localparam logic [7:0] MOD_CODE_MIN   = 8'hE0;
  localparam logic [7:0] SHIFT_CODE_MIN = 8'hC0;
  localparam logic [7:0] SHIFT_OFFSET   = 8'hA2;
  localparam logic [7:0] SHIFT_MOD_MASK = 8'h02;
  localparam logic [7:0] MOD_BIT_MASK   = 8'h0F;

  // result kinds
  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_BASE = 2'd0,
    OP_LOAD_FN   = 2'd1,
    OP_SCAN      = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [7:0]                  modifiers;
    logic [NUM_SLOTS-1:0][7:0]   keycodes;
  } report_t;

endpackage
`default_nettype wire

// ===== rtl/kmsh_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmsh_if
// Valid/ready channels of the scanner: item input, result output, config.
// ----------------------------------------------------------------------------
interface kmsh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] entry_index;
  logic [7:0] entry_code;
  logic [7:0] column_sample;

  modport source (output valid, opcode, entry_index, entry_code, column_sample,
                  input ready);
  modport sink   (input valid, opcode, entry_index, entry_code, column_sample,
                  output ready);
endinterface

interface kmsh_out_if #(
  parameter int unsigned ROWS = 5
);
  logic            valid;
  logic            ready;
  logic            result_kind;
  logic [ROWS-1:0] row_drive_n;
  logic [7:0]      report_byte;
  logic [2:0]      byte_index;
  logic            last;

  modport source (output valid, result_kind, row_drive_n, report_byte, byte_index,
                  last, input ready);
  modport sink   (input valid, result_kind, row_drive_n, report_byte, byte_index,
                  last, output ready);
endinterface

interface kmsh_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/key_matrix_scan_hid_report.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_scan_hid_report
// Key matrix scanner that emits row drive updates and 8-byte HID reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries map loads (base or Fn entry) and scan ticks; out_if carries
//   row drive updates and report bytes; cfg_if writes the Fn layer code.
//   A map load gives no result. A sampling tick, or
//   a comparing tick with no change in the snapshot, gives one row drive
//   update in the cycle after its transfer. A comparing tick with a change walks
//   every key position through the keymap memory, one read per cycle, and
//   repeats the walk on the Fn map when the Fn key is held. The 8 report
//   bytes then leave one per cycle while the receiver is ready.
//   in_if is ready only between items and while the output register is free
//   or being drained, so a stalled receiver holds the block without loss.
//   Reset clears the scan phase, both key snapshots and the Fn code; the
//   keymaps hold nothing until loaded. cfg_if is always ready.
// ----------------------------------------------------------------------------
module key_matrix_scan_hid_report
  import kmsh_pkg::*;
#(
  parameter int unsigned ROWS = 5
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kmsh_cfg_if.sink    cfg_if,
  kmsh_in_if.sink     in_if,
  kmsh_out_if.source  out_if
);

  localparam int unsigned MAP_SIZE = ROWS * COLS;
  localparam int unsigned ADDR_W   = $clog2(MAP_SIZE);
  localparam int unsigned PH_W     = $clog2(ROWS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUILD,
    S_EMIT
  } state_e;

  function automatic logic [ROWS-1:0] drive_for(logic [PH_W-1:0] row);
    logic [ROWS-1:0] v;
    if (row >= PH_W'(ROWS)) begin
      v = '1;
    end else begin
      v = ~(ROWS'(1) << row);
    end
    return v;
  endfunction

  state_e              state_q, state_d;
  logic [PH_W-1:0]     phase_q, phase_d;
  logic [MAP_SIZE-1:0] cur_q, cur_d;
  logic [MAP_SIZE-1:0] prev_q, prev_d;
  logic [7:0]          fn_code_q, fn_code_d;
  logic [2:0]          bc_q, bc_d;
  logic                out_vld_q, out_vld_d;
  logic                out_kind_q, out_kind_d;
  logic [ROWS-1:0]     out_drive_q, out_drive_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic [2:0]          out_idx_q, out_idx_d;
  logic                out_last_q, out_last_d;

  logic              in_xfer;
  logic              out_free;
  logic              in_range;
  logic              start;
  logic              we_base;
  logic              we_fn;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        base_code;
  logic [7:0]        fn_map_code;
  logic              rep_done;
  report_t           report;
  logic [7:0]        rep_byte;

  assign out_free  = !out_vld_q || out_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && out_free;
  assign in_xfer   = in_if.valid && in_if.ready;
  assign in_range  = {1'b0, in_if.entry_index} < 7'(MAP_SIZE);
  assign cfg_if.ready = 1'b1;

  always_comb begin
    case (bc_q)
      3'd0:    rep_byte = report.modifiers;
      3'd1:    rep_byte = '0;
      default: rep_byte = report.keycodes[3'(bc_q - 3'd2)];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    fn_code_d   = fn_code_q;
    bc_d        = bc_q;
    out_vld_d   = out_vld_q;
    out_kind_d  = out_kind_q;
    out_drive_d = out_drive_q;
    out_byte_d  = out_byte_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    start       = 1'b0;
    we_base     = 1'b0;
    we_fn       = 1'b0;

    if (cfg_if.valid && cfg_if.ready) begin
      fn_code_d = cfg_if.data;
    end
    if (out_vld_q && out_if.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (opcode_e'(in_if.opcode))
            OP_LOAD_BASE: we_base = in_range;
            OP_LOAD_FN:   we_fn   = in_range;
            OP_SCAN: begin
              out_kind_d = KIND_ROW;
              out_byte_d = '0;
              out_idx_d  = '0;
              out_last_d = 1'b1;
              if (phase_q < PH_W'(ROWS)) begin
                cur_d[phase_q * COLS +: COLS] = ~in_if.column_sample;
                phase_d     = PH_W'(phase_q + 1'b1);
                out_vld_d   = 1'b1;
                out_drive_d = drive_for(PH_W'(phase_q + 1'b1));
              end else begin
                phase_d = '0;
                if (cur_q != prev_q) begin
                  prev_d  = cur_q;
                  start   = 1'b1;
                  state_d = S_BUILD;
                end else begin
                  out_vld_d   = 1'b1;
                  out_drive_d = drive_for('0);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_BUILD: begin
        if (rep_done) begin
          bc_d    = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_kind_d  = KIND_REPORT;
          out_drive_d = drive_for('0);
          out_byte_d  = rep_byte;
          out_idx_d   = bc_q;
          out_last_d  = (bc_q == 3'(REPORT_BYTES - 1));
          bc_d        = bc_q + 1'b1;
          if (bc_q == 3'(REPORT_BYTES - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      fn_code_q   <= '0;
      bc_q        <= '0;
      out_vld_q   <= 1'b0;
      out_kind_q  <= KIND_ROW;
      out_drive_q <= '1;
      out_byte_q  <= '0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      fn_code_q   <= fn_code_d;
      bc_q        <= bc_d;
      out_vld_q   <= out_vld_d;
      out_kind_q  <= out_kind_d;
      out_drive_q <= out_drive_d;
      out_byte_q  <= out_byte_d;
      out_idx_q   <= out_idx_d;
      out_last_q  <= out_last_d;
    end
  end

  kmsh_keymap #(
    .DEPTH  (MAP_SIZE),
    .ADDR_W (ADDR_W)
  ) u_keymap (
    .clk_i     (clk_i),
    .we_base_i (we_base),
    .we_fn_i   (we_fn),
    .waddr_i   (in_if.entry_index[ADDR_W-1:0]),
    .wdata_i   (in_if.entry_code),
    .re_i      (rd_en),
    .raddr_i   (rd_addr),
    .base_o    (base_code),
    .fn_o      (fn_map_code)
  );

  kmsh_report #(
    .MAP_SIZE (MAP_SIZE),
    .ADDR_W   (ADDR_W)
  ) u_report (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .keys_i        (cur_q),
    .fn_code_i     (fn_code_q),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .base_code_i   (base_code),
    .fn_map_code_i (fn_map_code),
    .done_o        (rep_done),
    .report_o      (report)
  );

  assign out_if.valid       = out_vld_q;
  assign out_if.result_kind = out_kind_q;
  assign out_if.row_drive_n = out_drive_q;
  assign out_if.report_byte = out_byte_q;
  assign out_if.byte_index  = out_idx_q;
  assign out_if.last        = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/kmsh_keymap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmsh_keymap
// Base and Fn keymap storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kmsh_keymap #(
  parameter int unsigned DEPTH  = 40,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_base_i,
  input  wire logic              we_fn_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [7:0]        base_o,
  output logic      [7:0]        fn_o
);

  logic [7:0] base_mem_q [DEPTH];
  logic [7:0] fn_mem_q   [DEPTH];
  logic [7:0] base_q;
  logic [7:0] fn_q;

  always_ff @(posedge clk_i) begin
    if (we_base_i) begin
      base_mem_q[waddr_i] <= wdata_i;
    end
    if (we_fn_i) begin
      fn_mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      base_q <= base_mem_q[raddr_i];
      fn_q   <= fn_mem_q[raddr_i];
    end
  end

  assign base_o = base_q;
  assign fn_o   = fn_q;

endmodule
`default_nettype wire

// ===== rtl/kmsh_report.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmsh_report
// Walks all key positions through the keymap memory and builds the report.
// ----------------------------------------------------------------------------
module kmsh_report
  import kmsh_pkg::*;
#(
  parameter int unsigned MAP_SIZE = 40,
  parameter int unsigned ADDR_W   = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [MAP_SIZE-1:0] keys_i,
  input  wire logic [7:0]          fn_code_i,
  output logic                     rd_en_o,
  output logic      [ADDR_W-1:0]   rd_addr_o,
  input  wire logic [7:0]          base_code_i,
  input  wire logic [7:0]          fn_map_code_i,
  output logic                     done_o,
  output report_t                  report_o
);

  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(MAP_SIZE - 1);

  logic              iss_act_q, iss_act_d;
  logic [ADDR_W-1:0] iss_q, iss_d;
  logic              p_vld_q, p_vld_d;
  logic [ADDR_W-1:0] p_pos_q, p_pos_d;
  logic              fn_pass_q, fn_pass_d;
  logic              fn_seen_q, fn_seen_d;
  logic              done_q, done_d;
  logic [7:0]        mod_q, mod_d;
  logic [7:0]        slot_q [NUM_SLOTS];
  logic [7:0]        slot_d [NUM_SLOTS];
  logic [2:0]        cnt_q, cnt_d;

  logic [7:0] code;
  logic       pressed;
  logic       last_pos;

  assign code     = fn_pass_q ? fn_map_code_i : base_code_i;
  assign pressed  = p_vld_q && keys_i[p_pos_q];
  assign last_pos = p_vld_q && (p_pos_q == LAST_POS);

  always_comb begin
    iss_act_d = iss_act_q;
    iss_d     = iss_q;
    p_vld_d   = 1'b0;
    p_pos_d   = p_pos_q;
    fn_pass_d = fn_pass_q;
    fn_seen_d = fn_seen_q;
    done_d    = 1'b0;
    mod_d     = mod_q;
    slot_d    = slot_q;
    cnt_d     = cnt_q;

    if (start_i) begin
      iss_act_d = 1'b1;
      iss_d     = '0;
      fn_pass_d = 1'b0;
      fn_seen_d = 1'b0;
      mod_d     = '0;
      cnt_d     = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_d[i] = '0;
      end
    end else begin
      // read issue stage
      p_vld_d = iss_act_q;
      p_pos_d = iss_q;
      if (iss_act_q) begin
        iss_d = iss_q + 1'b1;
        if (iss_q == LAST_POS) begin
          iss_act_d = 1'b0;
        end
      end

      // accumulate stage, memory data is valid here
      if (pressed) begin
        if (!fn_pass_q && (base_code_i == fn_code_i)) begin
          fn_seen_d = 1'b1;
        end
        if (code >= MOD_CODE_MIN) begin
          // modifier bit beyond 7 is lost
          if (!code[3]) begin
            mod_d[code[2:0]] = 1'b1;
          end
        end else if (cnt_q < 3'(NUM_SLOTS)) begin
          if (code >= SHIFT_CODE_MIN) begin
            mod_d          = mod_d | SHIFT_MOD_MASK;
            slot_d[cnt_q]  = code - SHIFT_OFFSET;
          end else begin
            slot_d[cnt_q]  = code;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end

      // end of a pass: redo with the fn layer if its key was held
      if (last_pos) begin
        if (!fn_pass_q && fn_seen_d) begin
          fn_pass_d = 1'b1;
          iss_act_d = 1'b1;
          iss_d     = '0;
          mod_d     = '0;
          cnt_d     = '0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_d[i] = '0;
          end
        end else begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_act_q <= 1'b0;
      p_vld_q   <= 1'b0;
      fn_pass_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      iss_act_q <= iss_act_d;
      p_vld_q   <= p_vld_d;
      fn_pass_q <= fn_pass_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q     <= iss_d;
    p_pos_q   <= p_pos_d;
    fn_seen_q <= fn_seen_d;
    mod_q     <= mod_d;
    slot_q    <= slot_d;
    cnt_q     <= cnt_d;
  end

  assign rd_en_o   = iss_act_q;
  assign rd_addr_o = iss_q;
  assign done_o    = done_q;

  always_comb begin
    report_o.modifiers = mod_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      report_o.keycodes[i] = slot_q[i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kmsh_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmsh_checker
// Port-level checks on the result channel of the scanner.
// ----------------------------------------------------------------------------
module kmsh_checker #(
  parameter int unsigned ROWS = 5
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire logic            result_kind_i,
  input wire logic [ROWS-1:0] row_drive_n_i,
  input wire logic [7:0]      report_byte_i,
  input wire logic [2:0]      byte_index_i,
  input wire logic            last_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_kind_i) &&
    $stable(row_drive_n_i) && $stable(report_byte_i) && $stable(byte_index_i) &&
    $stable(last_i))
    else $error("result changed while stalled");

  // row drive update is a single, empty result
  a_row_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !result_kind_i |-> last_i && report_byte_i == 8'd0 &&
    byte_index_i == 3'd0)
    else $error("malformed row drive update");

  // report ends exactly at its eighth byte
  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i |-> last_i == (byte_index_i == 3'd7))
    else $error("report last flag misplaced");

  // reserved report byte stays zero
  a_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i && byte_index_i == 3'd1 |-> report_byte_i == 8'd0)
    else $error("reserved report byte not zero");

  // at most one row driven low
  a_one_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $countones(~row_drive_n_i) <= 1)
    else $error("more than one row driven");

endmodule

bind key_matrix_scan_hid_report kmsh_checker #(
  .ROWS (ROWS)
) u_kmsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .result_kind_i (out_if.result_kind),
  .row_drive_n_i (out_if.row_drive_n),
  .report_byte_i (out_if.report_byte),
  .byte_index_i  (out_if.byte_index),
  .last_i        (out_if.last)
);
`default_nettype wire
